// ----- sv/fcd_pkg.sv -----
package fcd_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 4096;
  localparam int MAX_HEIGHT_DEFAULT = 4096;

  localparam int SAMPLE_W      = 8;
  localparam int FRAME_W_BITS  = 13;
  localparam int CPP_W         = 3;
  localparam int PIXEL_W       = 25;
  localparam int MASK_W        = 12;
  localparam int COUNT_W       = 27;
  localparam int COMP_IDX_W    = 2;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 5;
  localparam int RECIP_W       = 26;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [PIXEL_W-1:0] PIXEL_MAX = {PIXEL_W{1'b1}};

  // (2^27 + 1) / 3, exact reciprocal for every 27-bit dividend.
  localparam logic [RECIP_W-1:0] RECIP_THREE = 26'd44739243;

  localparam logic [FRAME_W_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CPP_W-1:0]        CPP_RST          = 3'd3;
  localparam logic [SAMPLE_W-1:0]     DIFF_THRESH_RST  = 8'd15;
  localparam logic [PIXEL_W-1:0]      PIXEL_THRESH_RST = 25'd3072;
  localparam logic [MASK_W-1:0]       MASK_LEFT_RST    = 12'd368;
  localparam logic [MASK_W-1:0]       MASK_RIGHT_RST   = 12'd452;
  localparam logic [MASK_W-1:0]       MASK_TOP_RST     = 12'd21;
  localparam logic [MASK_W-1:0]       MASK_BOTTOM_RST  = 12'd45;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_CPP          = 3'd1,
    REG_DIFF_THRESH  = 3'd2,
    REG_PIXEL_THRESH = 3'd3,
    REG_MASK_LEFT    = 3'd4,
    REG_MASK_RIGHT   = 3'd5,
    REG_MASK_TOP     = 3'd6,
    REG_MASK_BOTTOM  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [FRAME_W_BITS-1:0] frame_width;
    logic [CPP_W-1:0]        components_per_pixel;
    logic [SAMPLE_W-1:0]     diff_threshold;
    logic [PIXEL_W-1:0]      pixel_limit;
    logic [MASK_W-1:0]       mask_left;
    logic [MASK_W-1:0]       mask_right;
    logic [MASK_W-1:0]       mask_top;
    logic [MASK_W-1:0]       mask_bottom;
  } cfg_t;

  typedef struct packed {
    logic advance;
    logic close;
    logic mult;
    logic publish;
  } cmd_t;

endpackage

// ----- sv/fcd_in_if.sv -----
interface fcd_in_if;
  import fcd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] current_sample;
  logic [SAMPLE_W-1:0] previous_sample;
  logic                last_of_frame;

  modport source (output valid, current_sample, previous_sample, last_of_frame,
                  input ready);
  modport sink (input valid, current_sample, previous_sample, last_of_frame,
                output ready);
endinterface

// ----- sv/fcd_out_if.sv -----
interface fcd_out_if;
  import fcd_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] changed_pixels;
  logic               frame_changed;

  modport source (output valid, changed_pixels, frame_changed, input ready);
  modport sink (input valid, changed_pixels, frame_changed, output ready);
endinterface

// ----- sv/fcd_regs.sv -----
module fcd_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fcd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fcd_pkg::APB_DATA_W-1:0] prdata,
  output fcd_pkg::cfg_t                  cfg
);
  import fcd_pkg::*;

  reg_index_t index;
  logic       write_en;

  assign index    = reg_index_t'(paddr[APB_ADDR_W-1:2]);
  assign write_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width           <= FRAME_WIDTH_RST;
      cfg.components_per_pixel  <= CPP_RST;
      cfg.diff_threshold        <= DIFF_THRESH_RST;
      cfg.pixel_limit           <= PIXEL_THRESH_RST;
      cfg.mask_left             <= MASK_LEFT_RST;
      cfg.mask_right            <= MASK_RIGHT_RST;
      cfg.mask_top              <= MASK_TOP_RST;
      cfg.mask_bottom           <= MASK_BOTTOM_RST;
    end else if (write_en) begin
      unique case (index)
        REG_FRAME_WIDTH:  cfg.frame_width           <= pwdata[FRAME_W_BITS-1:0];
        REG_CPP:          cfg.components_per_pixel  <= pwdata[CPP_W-1:0];
        REG_DIFF_THRESH:  cfg.diff_threshold        <= pwdata[SAMPLE_W-1:0];
        REG_PIXEL_THRESH: cfg.pixel_limit           <= pwdata[PIXEL_W-1:0];
        REG_MASK_LEFT:    cfg.mask_left             <= pwdata[MASK_W-1:0];
        REG_MASK_RIGHT:   cfg.mask_right            <= pwdata[MASK_W-1:0];
        REG_MASK_TOP:     cfg.mask_top              <= pwdata[MASK_W-1:0];
        REG_MASK_BOTTOM:  cfg.mask_bottom           <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg.frame_width);
      REG_CPP:          prdata = APB_DATA_W'(cfg.components_per_pixel);
      REG_DIFF_THRESH:  prdata = APB_DATA_W'(cfg.diff_threshold);
      REG_PIXEL_THRESH: prdata = APB_DATA_W'(cfg.pixel_limit);
      REG_MASK_LEFT:    prdata = APB_DATA_W'(cfg.mask_left);
      REG_MASK_RIGHT:   prdata = APB_DATA_W'(cfg.mask_right);
      REG_MASK_TOP:     prdata = APB_DATA_W'(cfg.mask_top);
      REG_MASK_BOTTOM:  prdata = APB_DATA_W'(cfg.mask_bottom);
      default:          prdata = '0;
    endcase
  end
endmodule

// ----- sv/fcd_ctrl.sv -----
module fcd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output fcd_pkg::cmd_t cmd
);
  import fcd_pkg::*;

  typedef enum logic [2:0] {
    S_RUN = 3'b001,
    S_MUL = 3'b010,
    S_PUB = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready    = (state == S_RUN);
  assign cmd.advance = in_valid && in_ready;
  assign cmd.close   = in_valid && in_ready && in_last;
  assign cmd.mult    = (state == S_MUL);
  assign cmd.publish = (state == S_PUB) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: if (cmd.close) state_next = S_MUL;
      S_MUL: state_next = S_PUB;
      S_PUB: if (cmd.publish) state_next = S_RUN;
      default: state_next = S_RUN;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

// ----- sv/fcd_datapath.sv -----
module fcd_datapath #(
  parameter int MAX_WIDTH  = fcd_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = fcd_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fcd_pkg::cmd_t                cmd,
  input  fcd_pkg::cfg_t                cfg,
  input  logic [fcd_pkg::SAMPLE_W-1:0] current_sample,
  input  logic [fcd_pkg::SAMPLE_W-1:0] previous_sample,
  output logic [fcd_pkg::PIXEL_W-1:0]  changed_pixels,
  output logic                         frame_changed
);
  import fcd_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = (CW + 1 > FRAME_W_BITS) ? CW + 1 : FRAME_W_BITS;
  localparam int MCW = (CW > MASK_W) ? CW : MASK_W;
  localparam int MRW = (RW > MASK_W) ? RW : MASK_W;
  localparam int PROD_W = COUNT_W + RECIP_W;

  logic [COMP_IDX_W-1:0] comp_index;
  logic [CW-1:0]         column;
  logic [RW-1:0]         row;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    held_count;
  logic [PROD_W-1:0]     product;

  logic [SAMPLE_W-1:0]   diff;
  logic                  masked;
  logic [COUNT_W-1:0]    count_next;
  logic [CPP_W-1:0]      cpp_eff;
  logic [WW-1:0]         width_eff;
  logic [WW-1:0]         column_inc;
  logic                  pixel_done;
  logic                  row_done;
  logic [COUNT_W-1:0]    quotient;
  logic [PIXEL_W-1:0]    pixels;

  assign diff = (current_sample > previous_sample) ? current_sample - previous_sample
                                                   : previous_sample - current_sample;

  assign masked = (MCW'(column) > MCW'(cfg.mask_left)) &&
                  (MCW'(column) < MCW'(cfg.mask_right)) &&
                  (MRW'(row) > MRW'(cfg.mask_top)) &&
                  (MRW'(row) < MRW'(cfg.mask_bottom));

  assign count_next = (!masked && (diff > cfg.diff_threshold) && (count != COUNT_MAX))
                      ? count + COUNT_W'(1) : count;

  always_comb begin
    if (cfg.components_per_pixel == '0) begin
      cpp_eff = CPP_W'(1);
    end else if (cfg.components_per_pixel > CPP_W'(4)) begin
      cpp_eff = CPP_W'(4);
    end else begin
      cpp_eff = cfg.components_per_pixel;
    end
  end

  always_comb begin
    if (cfg.frame_width == '0) begin
      width_eff = WW'(1);
    end else if (WW'(cfg.frame_width) > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(cfg.frame_width);
    end
  end

  assign column_inc = WW'(column) + WW'(1);
  assign pixel_done = (CPP_W'(comp_index) + CPP_W'(1)) >= cpp_eff;
  assign row_done   = column_inc >= width_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_index <= '0;
      column     <= '0;
      row        <= '0;
      count      <= '0;
    end else if (cmd.close) begin
      comp_index <= '0;
      column     <= '0;
      row        <= '0;
      count      <= '0;
    end else if (cmd.advance) begin
      count <= count_next;
      if (pixel_done) begin
        comp_index <= '0;
        if (row_done) begin
          column <= '0;
          if (row < RW'(MAX_HEIGHT - 1)) begin
            row <= row + RW'(1);
          end
        end else begin
          column <= column_inc[CW-1:0];
        end
      end else begin
        comp_index <= comp_index + COMP_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      held_count <= count_next;
    end
    if (cmd.mult) begin
      product <= PROD_W'(held_count) * PROD_W'(RECIP_THREE);
    end
  end

  always_comb begin
    case (cpp_eff)
      CPP_W'(2): quotient = held_count >> 1;
      CPP_W'(3): quotient = COUNT_W'(product[PROD_W-1:COUNT_W]);
      CPP_W'(4): quotient = held_count >> 2;
      default:   quotient = held_count;
    endcase
  end

  assign pixels = (quotient > COUNT_W'(PIXEL_MAX)) ? PIXEL_MAX : quotient[PIXEL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      changed_pixels <= pixels;
      frame_changed  <= pixels > cfg.pixel_limit;
    end
  end
endmodule

// ----- sv/frame_change_detector_unit.sv -----
// Frame change detector. Every sample beat carries one component byte of the
// current frame and the same byte of the previous frame, interleaved and in
// raster order. Beats outside the exclusion rectangle whose absolute difference
// exceeds diff_threshold are counted. The beat marked last_of_frame is counted
// too, and then one result beat gives that count divided by components_per_pixel
// and a flag that says whether it exceeds the changed-pixel limit register. All
// counters clear at the end of a frame; configuration registers keep their values.
// The block takes one sample beat per clock cycle. The end-of-frame beat holds off
// the sample port through the multiply and publish states while the divide runs
// as a reciprocal multiply (shifts for two or four components) and a registered
// select, and longer if the previous result has not yet been taken from the result port.
module frame_change_detector_unit #(
  parameter int MAX_WIDTH  = fcd_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = fcd_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  fcd_in_if.sink                         samples,
  fcd_out_if.source                      results,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fcd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fcd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import fcd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  assign pready = 1'b1;

  fcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  fcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_last   (samples.last_of_frame),
    .in_ready  (samples.ready),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .cmd       (cmd)
  );

  fcd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg             (cfg),
    .current_sample  (samples.current_sample),
    .previous_sample (samples.previous_sample),
    .changed_pixels  (results.changed_pixels),
    .frame_changed   (results.frame_changed)
  );
endmodule

// ----- sv/fcd_checker.sv -----
module fcd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fcd_pkg::PIXEL_W-1:0] changed_pixels,
  input logic                        frame_changed
);
  import fcd_pkg::*;

  // A pending result beat stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // A changed frame must report at least one changed pixel.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_changed |-> changed_pixels != '0)
    else $error("frame flagged changed with a zero pixel count");

  // The end-of-frame beat holds off the sample port for the divide.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready ##1 !in_ready)
    else $error("sample port reopened during the end-of-frame divide");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat offered right after reset");
endmodule

bind frame_change_detector_unit fcd_checker u_fcd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samples.valid),
  .in_ready       (samples.ready),
  .in_last        (samples.last_of_frame),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .changed_pixels (results.changed_pixels),
  .frame_changed  (results.frame_changed)
);
